// ----- design/pic_pkg.sv -----
// shared types, constants and decode functions of the panel input conditioner
package pic_pkg;

  // widths of the word fields
  localparam int unsigned CMD_W        = 1;
  localparam int unsigned TOUCH_BYTE_W = 8;
  localparam int unsigned PHASE_W      = 2;
  localparam int unsigned CODE_W       = 4;
  localparam int unsigned VALUE_W      = 2;
  localparam int unsigned DUR_W        = 32;
  localparam int unsigned STAMP_W      = 32;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_UART_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_SETTLE_SAMPLES = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_SETTLE_SAMPLES  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DETENT_STEPS          = 3'd4;

  localparam logic        RST_TOUCH_UART_MODE       = 1'b0;
  localparam logic [15:0] RST_LONG_PRESS_MS         = 16'd1500;
  localparam logic [3:0]  RST_BUTTON_SETTLE_SAMPLES = 4'd3;
  localparam logic [3:0]  RST_TOUCH_SETTLE_SAMPLES  = 4'd2;
  localparam logic [2:0]  RST_DETENT_STEPS          = 3'd2;

  localparam int unsigned DEFAULT_TIME_BITS = 32;

  // item commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ENCODER = 1'b1;

  // event codes
  localparam logic [CODE_W-1:0] EV_PRESS          = 4'd0;
  localparam logic [CODE_W-1:0] EV_RELEASE        = 4'd1;
  localparam logic [CODE_W-1:0] EV_LONG           = 4'd2;
  localparam logic [CODE_W-1:0] EV_DETENT         = 4'd3;
  localparam logic [CODE_W-1:0] EV_A_PRESS        = 4'd4;
  localparam logic [CODE_W-1:0] EV_A_RELEASE      = 4'd5;
  localparam logic [CODE_W-1:0] EV_B_PRESS        = 4'd6;
  localparam logic [CODE_W-1:0] EV_B_RELEASE      = 4'd7;
  localparam logic [CODE_W-1:0] EV_BOTH_PRESS     = 4'd8;
  localparam logic [CODE_W-1:0] EV_BOTH_RELEASE   = 4'd9;
  localparam logic [CODE_W-1:0] EV_LAST_CODE      = EV_BOTH_RELEASE;

  // decoded touch keys
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_A    = 2'd1;
  localparam logic [1:0] KEY_B    = 2'd2;
  localparam logic [1:0] KEY_BOTH = 2'd3;

  // raw touch codes
  localparam logic [7:0] I2C_CODE_A    = 8'h13;
  localparam logic [7:0] I2C_CODE_B    = 8'h12;
  localparam logic [7:0] I2C_CODE_BOTH = 8'h16;
  localparam logic [3:0] UART_NIB_A    = 4'h8;
  localparam logic [3:0] UART_NIB_B    = 4'h2;
  localparam logic [3:0] UART_NIB_BOTH = 4'hA;

  // event values
  localparam logic signed [VALUE_W-1:0] VAL_RELEASE = 2'sb00;
  localparam logic signed [VALUE_W-1:0] VAL_PRESS   = 2'sb01;
  localparam logic signed [VALUE_W-1:0] VAL_CW      = 2'sb01;
  localparam logic signed [VALUE_W-1:0] VAL_CCW     = 2'sb11;

  // batch queue between front and back
  localparam int unsigned MAX_EVENTS  = 3;
  localparam int unsigned COUNT_W     = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        touch_uart_mode;
    logic [15:0] long_press_ms;
    logic [3:0]  button_settle_samples;
    logic [3:0]  touch_settle_samples;
    logic [2:0]  detent_steps;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]         code;
    logic signed [VALUE_W-1:0] value;
    logic [DUR_W-1:0]          duration;
  } event_t;

  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    event_t [MAX_EVENTS-1:0]      ev;
    logic [STAMP_W-1:0]           timestamp;
  } batch_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // quadrature step for {previous, current} phases
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] touch_press_code(input logic [1:0] key);
    logic [CODE_W-1:0] c;
    unique case (key)
      KEY_A:   c = EV_A_PRESS;
      KEY_B:   c = EV_B_PRESS;
      default: c = EV_BOTH_PRESS;
    endcase
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] touch_release_code(input logic [1:0] key);
    logic [CODE_W-1:0] c;
    unique case (key)
      KEY_A:   c = EV_A_RELEASE;
      KEY_B:   c = EV_B_RELEASE;
      default: c = EV_BOTH_RELEASE;
    endcase
    return c;
  endfunction

endpackage

// ----- design/pic_item_if.sv -----
// input word channel: ticks and encoder samples
interface pic_item_if;
  import pic_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic                    button_level;
  logic                    touch_valid;
  logic [TOUCH_BYTE_W-1:0] touch_byte;
  logic [PHASE_W-1:0]      encoder_phases;

  modport source (
    output valid, command, button_level, touch_valid, touch_byte, encoder_phases,
    input  ready
  );

  modport sink (
    input  valid, command, button_level, touch_valid, touch_byte, encoder_phases,
    output ready
  );
endinterface

// ----- design/pic_event_if.sv -----
// output word channel: ui events
interface pic_event_if;
  import pic_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CODE_W-1:0]         event_code;
  logic signed [VALUE_W-1:0] event_value;
  logic [DUR_W-1:0]          event_span;
  logic [STAMP_W-1:0]        event_stamp;
  logic                      last_event;

  modport source (
    output valid, event_code, event_value, event_span, event_stamp, last_event,
    input  ready
  );

  modport sink (
    input  valid, event_code, event_value, event_span, event_stamp, last_event,
    output ready
  );
endinterface

// ----- design/pic_front.sv -----
// front end: takes input words, runs debounce and quadrature state, builds event batches
module pic_front #(
  parameter int unsigned TIME_BITS = pic_pkg::DEFAULT_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pic_pkg::cfg_t         cfg,
  pic_item_if.sink              items,
  input  pic_pkg::queue_status_t q_status,
  output logic                  push,
  output pic_pkg::batch_t       batch
);
  import pic_pkg::*;

  // state registers
  logic [TIME_BITS-1:0] tick_count, tick_count_next;
  logic [TIME_BITS-1:0] held, held_next;
  logic                 btn_sample, btn_sample_next;
  logic                 btn_state, btn_state_next;
  logic [3:0]           button_run, button_run_next;
  logic                 press_known, press_known_next;
  logic                 long_given, long_given_next;
  logic [1:0]           phase_previous, phase_previous_next;
  logic signed [3:0]    step_sum, step_sum_next;
  logic [1:0]           key_cand, key_cand_next;
  logic [1:0]           key_state, key_state_next;
  logic [3:0]           touch_run, touch_run_next;

  // working values
  logic                 accept;
  logic [TIME_BITS-1:0] held_step;
  logic [TIME_BITS-1:0] thr_wide;
  logic [15:0]          thr;
  logic [63:0]          tick_wide;
  logic [63:0]          held_wide;
  logic                 btn_change;
  logic                 touch_ok;
  logic [1:0]           touch_code;
  logic [3:0]           lo_nib;
  logic [3:0]           hi_nib;
  logic signed [1:0]    delta;
  logic signed [4:0]    sum5;
  logic signed [4:0]    lim5;
  logic [COUNT_W-1:0]   n;

  assign items.ready = !q_status.full;
  assign accept      = items.valid && items.ready;
  assign push        = accept && (batch.count != '0);

  always_comb begin
    tick_count_next      = tick_count;
    held_next            = held;
    btn_sample_next      = btn_sample;
    btn_state_next       = btn_state;
    button_run_next      = button_run;
    press_known_next     = press_known;
    long_given_next      = long_given;
    phase_previous_next  = phase_previous;
    step_sum_next        = step_sum;
    key_cand_next        = key_cand;
    key_state_next       = key_state;
    touch_run_next       = touch_run;
    batch                = '0;
    n                    = '0;
    held_step            = held + 1'b1;
    thr                  = (cfg.long_press_ms == 16'd0) ? 16'd1 : cfg.long_press_ms;
    thr_wide             = TIME_BITS'(thr);
    held_wide            = 64'(held_step);
    btn_change           = 1'b0;
    lo_nib               = items.touch_byte[3:0];
    hi_nib               = items.touch_byte[7:4];
    touch_ok             = 1'b1;
    touch_code           = KEY_NONE;
    delta                = 2'sd0;
    sum5                 = '0;
    lim5                 = $signed({2'b00, cfg.detent_steps});

    if (items.command == CMD_TICK) begin
      tick_count_next = tick_count + 1'b1;
      held_next       = held_step;

      // button debounce
      if (items.button_level != btn_sample) begin
        btn_sample_next = items.button_level;
        button_run_next = 4'd1;
      end else if (button_run < cfg.button_settle_samples) begin
        button_run_next = button_run + 4'd1;
      end
      btn_change = (button_run_next >= cfg.button_settle_samples) &&
                   (btn_state != btn_sample_next);
      if (btn_change) begin
        btn_state_next = btn_sample_next;
        if (!btn_sample_next) begin
          held_next        = '0;
          press_known_next = 1'b1;
          long_given_next  = 1'b0;
          batch.ev[n]      = '{code: EV_PRESS, value: VAL_PRESS, duration: '0};
          n                = n + 2'd1;
        end else begin
          press_known_next = 1'b0;
          batch.ev[n]      = '{code: EV_RELEASE, value: VAL_RELEASE,
                               duration: press_known ? held_wide[DUR_W-1:0] : '0};
          n                = n + 2'd1;
        end
      end

      // long press, once per press
      if (!btn_change && !btn_state && press_known && !long_given &&
          (held_step >= thr_wide)) begin
        long_given_next = 1'b1;
        batch.ev[n]     = '{code: EV_LONG, value: VAL_PRESS, duration: DUR_W'(thr)};
        n               = n + 2'd1;
      end

      // touch decode
      if (cfg.touch_uart_mode) begin
        touch_ok = (hi_nib == ~lo_nib);
        case (lo_nib)
          UART_NIB_A:    touch_code = KEY_A;
          UART_NIB_B:    touch_code = KEY_B;
          UART_NIB_BOTH: touch_code = KEY_BOTH;
          default:       touch_code = KEY_NONE;
        endcase
      end else begin
        case (items.touch_byte)
          I2C_CODE_A:    touch_code = KEY_A;
          I2C_CODE_B:    touch_code = KEY_B;
          I2C_CODE_BOTH: touch_code = KEY_BOTH;
          default:       touch_code = KEY_NONE;
        endcase
      end

      // touch debounce, release before press
      if (items.touch_valid && touch_ok) begin
        if (touch_code != key_cand) begin
          key_cand_next  = touch_code;
          touch_run_next = 4'd1;
        end else if (touch_run < cfg.touch_settle_samples) begin
          touch_run_next = touch_run + 4'd1;
        end
        if ((touch_run_next >= cfg.touch_settle_samples) &&
            (key_state != key_cand_next)) begin
          key_state_next = key_cand_next;
          if (key_state != KEY_NONE) begin
            batch.ev[n] = '{code: touch_release_code(key_state), value: VAL_RELEASE,
                            duration: '0};
            n           = n + 2'd1;
          end
          if (key_cand_next != KEY_NONE) begin
            batch.ev[n] = '{code: touch_press_code(key_cand_next), value: VAL_PRESS,
                            duration: '0};
            n           = n + 2'd1;
          end
        end
      end
    end else begin
      // quadrature step and detent
      if (items.encoder_phases != phase_previous) begin
        phase_previous_next = items.encoder_phases;
        delta               = quad_step({phase_previous, items.encoder_phases});
        if (delta != 2'sd0) begin
          sum5 = {step_sum[3], step_sum} + {{3{delta[1]}}, delta};
          if ((sum5 >= lim5) || (sum5 <= -lim5)) begin
            step_sum_next = '0;
            batch.ev[n]   = '{code: EV_DETENT, value: (sum5 > 5'sd0) ? VAL_CW : VAL_CCW,
                              duration: '0};
            n             = n + 2'd1;
          end else begin
            step_sum_next = sum5[3:0];
          end
        end
      end
    end

    tick_wide       = 64'(tick_count_next);
    batch.count     = n;
    batch.timestamp = tick_wide[STAMP_W-1:0];
  end

  // state update on accepted words
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      held           <= '0;
      btn_sample     <= 1'b1;
      btn_state      <= 1'b1;
      button_run     <= '0;
      press_known    <= 1'b0;
      long_given     <= 1'b0;
      phase_previous <= '0;
      step_sum       <= '0;
      key_cand       <= KEY_NONE;
      key_state      <= KEY_NONE;
      touch_run      <= '0;
    end else if (accept) begin
      tick_count     <= tick_count_next;
      held           <= held_next;
      btn_sample     <= btn_sample_next;
      btn_state      <= btn_state_next;
      button_run     <= button_run_next;
      press_known    <= press_known_next;
      long_given     <= long_given_next;
      phase_previous <= phase_previous_next;
      step_sum       <= step_sum_next;
      key_cand       <= key_cand_next;
      key_state      <= key_state_next;
      touch_run      <= touch_run_next;
    end
  end

endmodule

// ----- design/pic_queue.sv -----
// short batch queue between front and back
module pic_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pic_pkg::batch_t        wr_batch,
  input  logic                   pop,
  output pic_pkg::batch_t        rd_batch,
  output pic_pkg::queue_status_t status
);
  import pic_pkg::*;

  batch_t [QUEUE_DEPTH-1:0] entries;
  logic [QPTR_W-1:0]        wr_ptr;
  logic [QPTR_W-1:0]        rd_ptr;
  logic [QCNT_W-1:0]        count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign rd_batch     = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_batch;
    end
  end

endmodule

// ----- design/pic_back.sv -----
// back end: unpacks event batches and sends one event word per cycle while the receiver is ready
module pic_back (
  input  logic                   clk,
  input  logic                   rst,
  input  pic_pkg::batch_t        rd_batch,
  input  pic_pkg::queue_status_t q_status,
  output logic                   pop,
  pic_event_if.source            events
);
  import pic_pkg::*;

  batch_t             cur;
  logic               have;
  logic [COUNT_W-1:0] idx;
  logic               out_valid;
  logic               load;
  logic               last_idx;
  logic               fin;
  event_t             sel;

  assign load     = !out_valid || events.ready;
  assign last_idx = (idx == cur.count - 2'd1);
  assign fin      = have && load && last_idx;
  assign pop      = !q_status.empty && (!have || fin);
  assign sel      = cur.ev[idx];

  // current batch and event index
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      have <= 1'b1;
      idx  <= '0;
    end else if (fin) begin
      have <= 1'b0;
    end else if (have && load) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_batch;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= have;
    end
  end

  always_ff @(posedge clk) begin
    if (load && have) begin
      events.event_code  <= sel.code;
      events.event_value <= sel.value;
      events.event_span  <= sel.duration;
      events.event_stamp <= cur.timestamp;
      events.last_event  <= last_idx;
    end
  end

  assign events.valid = out_valid;

endmodule

// ----- design/panel_input_conditioner_unit.sv -----
// top level of the panel input conditioner: config registers, front, queue and back
//
// Use: words enter on the items channel (valid/ready). A command 0 word is a
// one-millisecond tick carrying the raw button level and an optional touch
// byte; a command 1 word is an encoder phase sample. Each word yields zero to
// three ui event words on the events channel, the last of them flagged by
// last_event. Registers are written through cfg_write/cfg_index/cfg_data;
// the user writes them only while the block is idle, which the block itself
// does not enforce. Unknown indexes are dropped. The first event of a word
// passes the batch queue, the current-batch register and the output
// register; the event side then sends one event per cycle while the
// receiver is ready. Throughput: a word is taken every cycle while the
// two-entry batch queue has room. Words with more events (three at most)
// hold the back end longer; words without events never enter the queue.
// Reset (rst, synchronous): counters and debounce state return to released and
// zero, registers to their defaults, queue and output register empty.
// Receiver stall: the output register holds its word; the queue fills and
// then items.ready drops until the back end drains.
module panel_input_conditioner_unit #(
  parameter int unsigned TIME_BITS = pic_pkg::DEFAULT_TIME_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pic_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pic_pkg::CFG_DATA_W-1:0]   cfg_data,
  pic_item_if.sink                         items,
  pic_event_if.source                      events
);
  import pic_pkg::*;

  cfg_t          cfg;
  batch_t        wr_batch;
  batch_t        rd_batch;
  queue_status_t q_status;
  logic          push;
  logic          pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touch_uart_mode       <= RST_TOUCH_UART_MODE;
      cfg.long_press_ms         <= RST_LONG_PRESS_MS;
      cfg.button_settle_samples <= RST_BUTTON_SETTLE_SAMPLES;
      cfg.touch_settle_samples  <= RST_TOUCH_SETTLE_SAMPLES;
      cfg.detent_steps          <= RST_DETENT_STEPS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOUCH_UART_MODE:       cfg.touch_uart_mode       <= cfg_data[0];
        REG_LONG_PRESS_MS:         cfg.long_press_ms         <= cfg_data[15:0];
        REG_BUTTON_SETTLE_SAMPLES: cfg.button_settle_samples <= cfg_data[3:0];
        REG_TOUCH_SETTLE_SAMPLES:  cfg.touch_settle_samples  <= cfg_data[3:0];
        REG_DETENT_STEPS:          cfg.detent_steps          <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  pic_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .items    (items),
    .q_status (q_status),
    .push     (push),
    .batch    (wr_batch)
  );

  pic_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_batch (wr_batch),
    .pop      (pop),
    .rd_batch (rd_batch),
    .status   (q_status)
  );

  pic_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_batch (rd_batch),
    .q_status (q_status),
    .pop      (pop),
    .events   (events)
  );

endmodule

// ----- design/pic_checker.sv -----
// port-level checks of the event channel, bound to the top level
module pic_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               ev_valid,
  input logic                               ev_ready,
  input logic [pic_pkg::CODE_W-1:0]         ev_code,
  input logic signed [pic_pkg::VALUE_W-1:0] ev_value,
  input logic [pic_pkg::DUR_W-1:0]          ev_duration
);
  import pic_pkg::*;

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !ev_valid)
    else $error("event word valid after reset");

  // stalled word stays valid and holds its code and duration
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid && $stable(ev_code) && $stable(ev_duration))
    else $error("stalled event word changed");

  // code in range, value never minus two
  a_code_value: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (ev_code <= EV_LAST_CODE) && (ev_value != 2'sb10))
    else $error("bad event code or value");

  // only release and long carry a duration
  a_dur_zero: assert property (@(posedge clk) disable iff (rst)
    ev_valid && (ev_code != EV_RELEASE) && (ev_code != EV_LONG) |-> ev_duration == '0)
    else $error("duration on event without one");

  // long press carries a nonzero threshold and value one
  a_long: assert property (@(posedge clk) disable iff (rst)
    ev_valid && (ev_code == EV_LONG) |-> (ev_duration != '0) && (ev_value == VAL_PRESS))
    else $error("malformed long press word");

endmodule

bind panel_input_conditioner_unit pic_checker u_pic_checker (
  .clk         (clk),
  .rst         (rst),
  .ev_valid    (events.valid),
  .ev_ready    (events.ready),
  .ev_code     (events.event_code),
  .ev_value    (events.event_value),
  .ev_duration (events.event_span)
);

// ----- tb/panel_input_conditioner_unit_test.sv -----
// self-checking testbench of the panel input conditioner: event prediction and scoreboard
module panel_input_conditioner_unit_test;
  import pic_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // one predicted or observed ui event word
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [DUR_W-1:0]   dur;
    logic [STAMP_W-1:0] stamp;
    logic               last;
  } ui_event_t;

  // predicts ui events from accepted words and checks the event stream
  class ui_event_scoreboard;
    logic        uart_mode;
    logic [15:0] long_ms;
    logic [3:0]  btn_settle;
    logic [3:0]  touch_settle;
    logic [2:0]  detent_len;

    logic [31:0] ticks;
    logic        btn_cand;
    logic        btn_stable;
    logic [3:0]  btn_run;
    logic [31:0] press_at;
    logic        press_known;
    logic        long_done;
    logic [1:0]  phase_prev;
    int          step_acc;
    logic [1:0]  touch_cand;
    logic [1:0]  key_state;
    logic [3:0]  touch_run;

    ui_event_t   due_events[$];
    ui_event_t   batch[$];
    int          errors;

    function new();
      uart_mode    = RST_TOUCH_UART_MODE;
      long_ms      = RST_LONG_PRESS_MS;
      btn_settle   = RST_BUTTON_SETTLE_SAMPLES;
      touch_settle = RST_TOUCH_SETTLE_SAMPLES;
      detent_len   = RST_DETENT_STEPS;
      ticks        = '0;
      btn_cand     = 1'b1;
      btn_stable   = 1'b1;
      btn_run      = '0;
      press_at     = '0;
      press_known  = 1'b0;
      long_done    = 1'b0;
      phase_prev   = '0;
      step_acc     = 0;
      touch_cand   = KEY_NONE;
      key_state    = KEY_NONE;
      touch_run    = '0;
      errors       = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TOUCH_UART_MODE:       uart_mode = data[0];
        REG_LONG_PRESS_MS:         long_ms = data[15:0];
        REG_BUTTON_SETTLE_SAMPLES: btn_settle = data[3:0];
        REG_TOUCH_SETTLE_SAMPLES:  touch_settle = data[3:0];
        REG_DETENT_STEPS:          detent_len = data[2:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_events.size();
    endfunction

    function void push_event(input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value,
                             input logic [DUR_W-1:0] dur);
      ui_event_t e;
      e.code  = code;
      e.value = value;
      e.dur   = dur;
      e.stamp = ticks;
      e.last  = 1'b0;
      batch.push_back(e);
    endfunction

    // decoded touch key, ok low when the uart nibble check fails
    function logic [1:0] touch_key(input logic [7:0] b, output logic ok);
      ok = 1'b1;
      if (uart_mode) begin
        if (b[7:4] != ~b[3:0]) begin
          ok = 1'b0;
          return KEY_NONE;
        end
        if (b[3:0] == UART_NIB_A) return KEY_A;
        if (b[3:0] == UART_NIB_B) return KEY_B;
        if (b[3:0] == UART_NIB_BOTH) return KEY_BOTH;
        return KEY_NONE;
      end
      if (b == I2C_CODE_A) return KEY_A;
      if (b == I2C_CODE_B) return KEY_B;
      if (b == I2C_CODE_BOTH) return KEY_BOTH;
      return KEY_NONE;
    endfunction

    function logic [CODE_W-1:0] key_press(input logic [1:0] k);
      case (k)
        KEY_A:   return EV_A_PRESS;
        KEY_B:   return EV_B_PRESS;
        default: return EV_BOTH_PRESS;
      endcase
    endfunction

    function logic [CODE_W-1:0] key_release(input logic [1:0] k);
      case (k)
        KEY_A:   return EV_A_RELEASE;
        KEY_B:   return EV_B_RELEASE;
        default: return EV_BOTH_RELEASE;
      endcase
    endfunction

    // quadrature step for {previous, current}
    function int quad_delta(input logic [3:0] idx);
      case (idx)
        4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
        4'b0010, 4'b0100, 4'b1011, 4'b1101: return 1;
        default: return 0;
      endcase
    endfunction

    function void predict_item(input logic [CMD_W-1:0] cmd, input logic level,
                               input logic tv, input logic [7:0] tbyte,
                               input logic [1:0] ph);
      logic [31:0] held;
      logic [31:0] thr;
      logic        ok;
      logic [1:0]  k;
      logic [1:0]  prev;
      int          delta;
      int          lim;
      ui_event_t   e;
      batch.delete();
      if (cmd == CMD_TICK) begin
        ticks = ticks + 32'd1;
        // button debounce
        if (level != btn_cand) begin
          btn_cand = level;
          btn_run = 4'd1;
        end else if (btn_run < btn_settle) begin
          btn_run = btn_run + 4'd1;
        end
        if (btn_run >= btn_settle && btn_stable != btn_cand) begin
          btn_stable = btn_cand;
          if (btn_stable == 1'b0) begin
            press_at = ticks;
            press_known = 1'b1;
            long_done = 1'b0;
            push_event(EV_PRESS, VAL_PRESS, '0);
          end else begin
            held = press_known ? ticks - press_at : 32'd0;
            push_event(EV_RELEASE, VAL_RELEASE, held);
            press_known = 1'b0;
            press_at = '0;
          end
        end
        // long press, zero threshold counts as one tick
        thr = (long_ms != 16'd0) ? {16'd0, long_ms} : 32'd1;
        if (btn_stable == 1'b0 && press_known && !long_done && (ticks - press_at) >= thr) begin
          long_done = 1'b1;
          push_event(EV_LONG, VAL_PRESS, thr);
        end
        // touch decode and debounce, a bad uart byte leaves it alone
        if (tv) begin
          k = touch_key(tbyte, ok);
          if (ok) begin
            if (k != touch_cand) begin
              touch_cand = k;
              touch_run = 4'd1;
            end else if (touch_run < touch_settle) begin
              touch_run = touch_run + 4'd1;
            end
            if (touch_run >= touch_settle && key_state != touch_cand) begin
              prev = key_state;
              key_state = touch_cand;
              if (prev != KEY_NONE) push_event(key_release(prev), VAL_RELEASE, '0);
              if (key_state != KEY_NONE) push_event(key_press(key_state), VAL_PRESS, '0);
            end
          end
        end
      end else if (ph != phase_prev) begin
        // encoder: repeats ignored, zero steps only move the phase
        delta = quad_delta({phase_prev, ph});
        phase_prev = ph;
        if (delta != 0) begin
          step_acc = step_acc + delta;
          lim = int'(detent_len);
          if (step_acc >= lim || step_acc <= -lim) begin
            push_event(EV_DETENT, (step_acc > 0) ? VAL_CW : VAL_CCW, '0);
            step_acc = 0;
          end
        end
      end
      // flag the last event of the word
      if (batch.size() > 0) begin
        e = batch.pop_back();
        e.last = 1'b1;
        batch.push_back(e);
      end
      foreach (batch[i]) due_events.push_back(batch[i]);
    endfunction

    task report(input string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_event(input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value,
                     input logic [DUR_W-1:0] dur, input logic [STAMP_W-1:0] stamp,
                     input logic last);
      ui_event_t e;
      if (due_events.size() == 0) begin
        report($sformatf("event word with none due: code %0d stamp %0d", code, stamp));
        return;
      end
      e = due_events.pop_front();
      if (code !== e.code)
        report($sformatf("event_code %0d, want %0d (stamp %0d)", code, e.code, e.stamp));
      if (value !== e.value)
        report($sformatf("event_value %b, want %b (stamp %0d)", value, e.value, e.stamp));
      if (dur !== e.dur)
        report($sformatf("event_span %0d, want %0d (stamp %0d)", dur, e.dur, e.stamp));
      if (stamp !== e.stamp)
        report($sformatf("event_stamp %0d, want %0d", stamp, e.stamp));
      if (last !== e.last)
        report($sformatf("last_event %b, want %b (stamp %0d)", last, e.last, e.stamp));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   idle_on;
  int unsigned            cycle_count = 0;

  // stimulus generator state
  logic                   btn_goal;
  int                     btn_hold;
  logic [1:0]             touch_goal;
  int                     touch_hold;
  int                     gray_pos;
  int                     enc_dir;
  logic [1:0]             enc_last;

  ui_event_scoreboard     sb;

  pic_item_if  items_if ();
  pic_event_if events_if ();

  panel_input_conditioner_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .events    (events_if)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    events_if.ready <= idle_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
  end

  // watch config writes, accepted words in and event words out
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (items_if.valid && items_if.ready)
        sb.predict_item(items_if.command, items_if.button_level, items_if.touch_valid,
                        items_if.touch_byte, items_if.encoder_phases);
      if (events_if.valid && events_if.ready)
        sb.check_event(events_if.event_code, events_if.event_value, events_if.event_span,
                       events_if.event_stamp, events_if.last_event);
    end
  end

  // offer one word after a random gap and wait for it to be taken
  task send_item(input logic [CMD_W-1:0] cmd, input logic level, input logic tv,
                 input logic [7:0] tbyte, input logic [1:0] ph);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(0, 99) < 25) gap++;
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid          <= 1'b1;
    items_if.command        <= cmd;
    items_if.button_level   <= level;
    items_if.touch_valid    <= tv;
    items_if.touch_byte     <= tbyte;
    items_if.encoder_phases <= ph;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
  endtask

  task tick(input logic level, input logic tv, input logic [7:0] tbyte);
    send_item(CMD_TICK, level, tv, tbyte, 2'($urandom_range(0, 3)));
  endtask

  task enc(input logic [1:0] ph);
    send_item(CMD_ENCODER, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), ph);
  endtask

  // hold the sender until every due event has come out
  task wait_events_done();
    items_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // one register write, then cfg_write is dropped again before the task returns
  task program_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // idle the block, then load a full register set
  task load_setting(input logic uart, input logic [15:0] long_ms, input logic [3:0] bset,
                    input logic [3:0] tset, input logic [2:0] dsteps);
    wait_events_done();
    repeat (6) @(posedge clk);
    program_reg(REG_TOUCH_UART_MODE, {15'd0, uart});
    program_reg(REG_LONG_PRESS_MS, long_ms);
    program_reg(REG_BUTTON_SETTLE_SAMPLES, {12'd0, bset});
    program_reg(REG_TOUCH_SETTLE_SAMPLES, {12'd0, tset});
    program_reg(REG_DETENT_STEPS, {13'd0, dsteps});
  endtask

  // raw touch byte for a key in the current code set
  function logic [7:0] touch_encode(input logic [1:0] k, input logic uart);
    logic [3:0] lo;
    if (uart) begin
      case (k)
        KEY_A:    lo = UART_NIB_A;
        KEY_B:    lo = UART_NIB_B;
        KEY_BOTH: lo = UART_NIB_BOTH;
        default:  lo = 4'(($urandom_range(0, 7) << 1) | 1);
      endcase
      return {~lo, lo};
    end
    case (k)
      KEY_A:    return I2C_CODE_A;
      KEY_B:    return I2C_CODE_B;
      KEY_BOTH: return I2C_CODE_BOTH;
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function logic [1:0] gray_phase(input int pos);
    case (pos)
      0:       return 2'b00;
      1:       return 2'b10;
      2:       return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  // mostly held presses, steady touches and clean rotation, with bounce and noise
  task run_random(input int count, input int bset, input int tset, input logic uart);
    int         r;
    logic       level;
    logic       tv;
    logic [7:0] tbyte;
    logic [1:0] ph;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) wait_events_done();
      if ($urandom_range(0, 99) < 55) begin
        if (btn_hold == 0) begin
          btn_goal = ~btn_goal;
          btn_hold = $urandom_range(1, 2 * bset + 25);
        end else begin
          btn_hold--;
        end
        if (touch_hold == 0) begin
          touch_goal = 2'($urandom_range(0, 3));
          touch_hold = $urandom_range(1, 2 * tset + 12);
        end else begin
          touch_hold--;
        end
        level = ($urandom_range(0, 99) < 8) ? ~btn_goal : btn_goal;
        tv    = ($urandom_range(0, 99) < 75);
        tbyte = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(0, 255))
                                             : touch_encode(touch_goal, uart);
        tick(level, tv, tbyte);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) enc_dir = -enc_dir;
        if (r < 80) begin
          gray_pos = (gray_pos + enc_dir + 4) % 4;
          ph = gray_phase(gray_pos);
        end else if (r < 88) begin
          ph = enc_last;
        end else begin
          ph = 2'($urandom_range(0, 3));
        end
        enc_last = ph;
        enc(ph);
      end
    end
  endtask

  // main sequence
  initial begin
    items_if.valid          <= 1'b0;
    items_if.command        <= CMD_TICK;
    items_if.button_level   <= 1'b1;
    items_if.touch_valid    <= 1'b0;
    items_if.touch_byte     <= '0;
    items_if.encoder_phases <= '0;
    cfg_write               <= 1'b0;
    cfg_index               <= '0;
    cfg_data                <= '0;
    rst                     <= 1'b1;
    idle_on                  = 1'b1;
    btn_goal                 = 1'b1;
    btn_hold                 = 0;
    touch_goal               = KEY_NONE;
    touch_hold               = 0;
    gray_pos                 = 0;
    enc_dir                  = 1;
    enc_last                 = 2'b00;
    sb                       = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: rotation both ways, repeat and diagonal samples
    enc(2'b10);
    enc(2'b11);
    enc(2'b11);
    enc(2'b00);
    enc(2'b01);
    enc(2'b11);
    // button press, touch changes, release together with a touch swap
    tick(1'b0, 1'b1, I2C_CODE_A);
    tick(1'b0, 1'b1, I2C_CODE_A);
    tick(1'b0, 1'b0, 8'hFF);
    tick(1'b1, 1'b1, I2C_CODE_BOTH);
    tick(1'b1, 1'b0, 8'h00);
    tick(1'b1, 1'b1, I2C_CODE_BOTH);
    tick(1'b1, 1'b1, I2C_CODE_B);
    tick(1'b1, 1'b1, I2C_CODE_B);
    tick(1'b0, 1'b1, 8'h00);
    tick(1'b1, 1'b1, 8'h00);

    // zero threshold, zero settle counts, zero detent steps, unknown index
    load_setting(1'b1, 16'd0, 4'd0, 4'd0, 3'd0);
    program_reg(3'd7, 16'hFFFF);
    tick(1'b0, 1'b1, 8'h78);
    tick(1'b0, 1'b1, 8'h88);
    tick(1'b0, 1'b1, 8'h5A);
    tick(1'b1, 1'b1, 8'h2D);
    enc(2'b10);
    enc(2'b00);
    enc(2'b11);
    tick(1'b1, 1'b1, 8'hB4);

    // random phases over several settings
    load_setting(1'b0, 16'd20, 4'd3, 4'd2, 3'd2);
    run_random(70, 3, 2, 1'b0);
    load_setting(1'b1, 16'hFFFF, 4'd15, 4'd15, 3'd7);
    run_random(60, 15, 15, 1'b1);
    load_setting(1'b1, 16'd1, 4'd1, 4'd1, 3'd4);
    run_random(60, 1, 1, 1'b1);
    load_setting(1'b0, 16'd5, 4'd2, 4'd3, 3'd1);
    idle_on = 1'b0;
    run_random(90, 2, 3, 1'b0);

    // drain and finish
    wait_events_done();
    repeat (12) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d events never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pic_pkg.sv
design/pic_item_if.sv
design/pic_event_if.sv
design/pic_front.sv
design/pic_queue.sv
design/pic_back.sv
design/panel_input_conditioner_unit.sv
design/pic_checker.sv
tb/panel_input_conditioner_unit_test.sv
